### design/acss_pkg.sv
// ----------------------------------------------------------------------------
// acss_pkg: shared types and constants for the converter scan sequencer
// Register indexes, widths and the word structs passed between the
// handshake shell and the scan core.
// ----------------------------------------------------------------------------
package acss_pkg;

    // Default channel count of the converter
    localparam int DEFAULT_CHANNELS = 4;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int MTIME_W    = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_CH_W   = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;

    // Reset values of the configuration registers
    localparam logic [MTIME_W-1:0] MEASURE_TIME_RESET = MTIME_W'(100);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_ENABLE   = 2'd0,
        REG_MEASURE_TIME  = 2'd1,
        REG_SEND_INTERVAL = 2'd2,
        REG_SEND_ENABLE   = 2'd3
    } cfg_reg_t;

    // One configuration write
    typedef struct packed {
        logic                  wr;
        cfg_reg_t              index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // One input word, unpacked
    typedef struct packed {
        logic                       ms_tick;
        logic                       rdy_edge;
        logic                       conv_done;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       device_error;
        logic [OUT_CH_W-1:0]        read_channel;
    } item_t;

    // One result word, unpacked
    typedef struct packed {
        logic                       request_conversion;
        logic [OUT_CH_W-1:0]        request_channel;
        logic                       publish;
        logic signed [SAMPLE_W-1:0] value_ch0;
        logic signed [SAMPLE_W-1:0] value_ch1;
        logic signed [SAMPLE_W-1:0] value_ch2;
        logic signed [SAMPLE_W-1:0] value_ch3;
        logic                       values_ready;
        logic                       timeout;
        logic                       status_ok;
        logic signed [SAMPLE_W-1:0] read_value;
    } result_t;

endpackage

### design/acss_scan_core.sv
// ----------------------------------------------------------------------------
// acss_scan_core: scan state machine, sample store and timers
// Holds the configuration registers and all scan state; computes the result
// of one accepted word and updates the state at the same edge.
// ----------------------------------------------------------------------------
module acss_scan_core #(
    parameter int CHANNELS = acss_pkg::DEFAULT_CHANNELS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  acss_pkg::cfg_wr_t cfg_wr,
    input  logic              item_accept,
    input  acss_pkg::item_t   item,
    output acss_pkg::result_t result
);

    localparam int CH_W = $clog2(CHANNELS);
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [acss_pkg::TIME_W-1:0] CH_COUNT = acss_pkg::TIME_W'(CHANNELS);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_REQUEST = 4'b0010,
        PH_STORE   = 4'b0100,
        PH_DELAY   = 4'b1000
    } phase_t;

    typedef logic [acss_pkg::TIME_W-1:0]   time_t;
    typedef logic [acss_pkg::SAMPLE_W-1:0] sample_t;

    // Configuration registers
    logic                           scan_enable_reg;
    logic [acss_pkg::MTIME_W-1:0]   measure_time_reg;
    time_t                          send_interval_reg;
    logic                           send_enable_reg;

    // Scan state
    time_t             now_reg, now_next;
    phase_t            phase_reg, phase_next;
    logic [CH_W-1:0]   chan_reg, chan_next;
    sample_t           store_reg [CHANNELS];
    sample_t           store_next [CHANNELS];
    logic              pending_reg, pending_next;
    time_t             settle_reg, settle_next;
    time_t             send_reg, send_next;
    time_t             wdog_reg, wdog_next;
    logic              sweep_reg, sweep_next;

    time_t             wd_time;
    time_t             send_time;
    logic              req;
    logic [CH_W-1:0]   req_ch;
    logic              pub;
    logic              tmo;
    sample_t           value_out [4];
    sample_t           read_out;

    function automatic logic elapsed(input time_t now, input time_t start, input time_t dur);
        time_t diff;
        diff = now - start;
        return diff >= dur;
    endfunction

    // Watchdog and publish intervals
    assign wd_time   = {{(acss_pkg::TIME_W - acss_pkg::MTIME_W){1'b0}}, measure_time_reg}
                       * CH_COUNT;
    assign send_time = (send_interval_reg > wd_time) ? send_interval_reg : wd_time;

    // Advance the scan machine for one word
    always_comb
    begin
        now_next     = now_reg;
        phase_next   = phase_reg;
        chan_next    = chan_reg;
        store_next   = store_reg;
        pending_next = pending_reg;
        settle_next  = settle_reg;
        send_next    = send_reg;
        wdog_next    = wdog_reg;
        sweep_next   = sweep_reg;
        req          = 1'b0;
        req_ch       = '0;
        pub          = 1'b0;
        tmo          = 1'b0;

        if (item_accept)
        begin
            now_next = now_reg + time_t'(item.ms_tick);
            if (scan_enable_reg)
            begin
                if (item.rdy_edge)
                begin
                    pending_next = 1'b1;
                end
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (pending_next)
                        begin
                            pending_next = 1'b0;
                            phase_next   = PH_STORE;
                        end
                    end
                    PH_REQUEST:
                    begin
                        req        = 1'b1;
                        req_ch     = chan_reg;
                        wdog_next  = now_next;
                        phase_next = PH_IDLE;
                    end
                    PH_STORE:
                    begin
                        if (item.conv_done)
                        begin
                            store_next[chan_reg] = sample_t'(item.sample);
                            if (chan_reg == LAST_CH)
                            begin
                                sweep_next = 1'b1;
                            end
                            settle_next = now_next;
                            phase_next  = PH_DELAY;
                        end
                    end
                    PH_DELAY:
                    begin
                        if (elapsed(now_next, settle_reg, time_t'(measure_time_reg)))
                        begin
                            if (sweep_reg && send_enable_reg
                                && elapsed(now_next, send_reg, send_time))
                            begin
                                send_next = now_next;
                                pub       = 1'b1;
                            end
                            chan_next  = (chan_reg == LAST_CH) ? '0 : chan_reg + 1'b1;
                            phase_next = PH_REQUEST;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
                // Restart the request when the watchdog runs out
                if (elapsed(now_next, wdog_next, wd_time))
                begin
                    wdog_next  = now_next;
                    phase_next = PH_REQUEST;
                    tmo        = 1'b1;
                end
            end
        end

        // Scan enable writes restart or stop the machine
        if (cfg_wr.wr && cfg_wr.index == acss_pkg::REG_SCAN_ENABLE)
        begin
            sweep_next = 1'b0;
            if (cfg_wr.data[0])
            begin
                phase_next   = PH_REQUEST;
                pending_next = 1'b0;
                send_next    = now_next;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Stored values on the fixed outputs
    for (genvar n = 0; n < 4; n++)
    begin : g_value
        if (n < CHANNELS)
        begin : g_used
            assign value_out[n] = store_next[n];
        end
        else
        begin : g_unused
            assign value_out[n] = '0;
        end
    end

    // Read back the selected channel
    always_comb
    begin
        read_out = '0;
        if (int'(item.read_channel) < CHANNELS)
        begin
            read_out = store_next[CH_W'(item.read_channel)];
        end
    end

    // Assemble the result word
    always_comb
    begin
        result.request_conversion = req;
        result.request_channel    = acss_pkg::OUT_CH_W'(req_ch);
        result.publish            = pub;
        result.value_ch0          = value_out[0];
        result.value_ch1          = value_out[1];
        result.value_ch2          = value_out[2];
        result.value_ch3          = value_out[3];
        result.values_ready       = sweep_next;
        result.timeout            = tmo;
        result.status_ok          = !tmo && !item.device_error;
        result.read_value         = read_out;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg   <= 1'b0;
            measure_time_reg  <= acss_pkg::MEASURE_TIME_RESET;
            send_interval_reg <= '0;
            send_enable_reg   <= 1'b0;
        end
        else if (cfg_wr.wr)
        begin
            case (cfg_wr.index)
                acss_pkg::REG_SCAN_ENABLE:   scan_enable_reg   <= cfg_wr.data[0];
                acss_pkg::REG_MEASURE_TIME:  measure_time_reg  <= cfg_wr.data[15:0];
                acss_pkg::REG_SEND_INTERVAL: send_interval_reg <= cfg_wr.data;
                acss_pkg::REG_SEND_ENABLE:   send_enable_reg   <= cfg_wr.data[0];
                default:                     send_enable_reg   <= send_enable_reg;
            endcase
        end
    end

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg     <= '0;
            phase_reg   <= PH_IDLE;
            chan_reg    <= '0;
            store_reg   <= '{default: '0};
            pending_reg <= 1'b0;
            settle_reg  <= '0;
            send_reg    <= '0;
            wdog_reg    <= '0;
            sweep_reg   <= 1'b0;
        end
        else
        begin
            now_reg     <= now_next;
            phase_reg   <= phase_next;
            chan_reg    <= chan_next;
            store_reg   <= store_next;
            pending_reg <= pending_next;
            settle_reg  <= settle_next;
            send_reg    <= send_next;
            wdog_reg    <= wdog_next;
            sweep_reg   <= sweep_next;
        end
    end

endmodule

### design/adc_channel_scan_sequencer.sv
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer: round-robin converter scan controller
// Requests conversions channel by channel, stores samples, publishes after
// each sweep under a rate limit, and restarts a stalled request on timeout.
// ----------------------------------------------------------------------------
// Output: each result word appears in the cycle after its input word is taken.
// Throughput: one word per cycle while the output is taken; its register frees
// as it is taken, so input and output words may move in the same cycle.
// Reset: rst_n clears all scan state, stored samples and the output valid;
// configuration registers return to their reset values (measure time 100).
module adc_channel_scan_sequencer #(
    parameter int CHANNELS = acss_pkg::DEFAULT_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // ms_tick[0], rdy_edge[1], conv_done[2], sample[18:3], device_error[19],
    // read_channel[21:20], zero pad [23:22]
    input  logic [acss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // request_conversion[0], request_channel[2:1], publish[3],
    // value_ch0[19:4], value_ch1[35:20], value_ch2[51:36], value_ch3[67:52],
    // values_ready[68], timeout[69], status_ok[70], read_value[86:71],
    // zero pad [87]
    output logic [acss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                                out_valid_reg;
    logic [acss_pkg::OUT_DATA_W-1:0]     out_data_reg;
    logic [acss_pkg::OUT_DATA_W-1:0]     out_data_next;
    logic                                in_accept;
    acss_pkg::cfg_wr_t                   cfg_wr;
    acss_pkg::item_t                     item;
    acss_pkg::result_t                   result;

    // Take a word whenever the output register is free or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Unpack the input word
    assign item.ms_tick      = s_axis_tdata[0];
    assign item.rdy_edge     = s_axis_tdata[1];
    assign item.conv_done    = s_axis_tdata[2];
    assign item.sample       = s_axis_tdata[18:3];
    assign item.device_error = s_axis_tdata[19];
    assign item.read_channel = s_axis_tdata[21:20];

    assign cfg_wr.wr    = cfg_valid && cfg_ready;
    assign cfg_wr.index = acss_pkg::cfg_reg_t'(cfg_index);
    assign cfg_wr.data  = cfg_data;

    acss_scan_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .item_accept (in_accept),
        .item        (item),
        .result      (result)
    );

    // Pack the result word
    assign out_data_next = {1'b0,
                            result.read_value,
                            result.status_ok,
                            result.timeout,
                            result.values_ready,
                            result.value_ch3,
                            result.value_ch2,
                            result.value_ch1,
                            result.value_ch0,
                            result.publish,
                            result.request_channel,
                            result.request_conversion};

    // Hold the result word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
